// ----- rtl/rtcbcd_pkg.sv -----
// Shared types, constants and helper functions for the RTC date/time register decoder.
// Used by every module of the block; no dependencies of its own.
package rtcbcd_pkg;

  localparam int BASE_YEAR = 2000;
  localparam int LAST_YEAR = 2199;
  localparam int YEAR_W    = 12;

  localparam int BASE_MOD100 = BASE_YEAR % 100;
  localparam int BASE_CENT   = BASE_YEAR / 100;

  localparam logic [YEAR_W-1:0] BASE_YEAR_V   = YEAR_W'(BASE_YEAR);
  localparam logic [YEAR_W-1:0] LAST_YEAR_V   = YEAR_W'(LAST_YEAR);
  localparam logic [YEAR_W-1:0] CENTURY_YEARS = YEAR_W'(100);
  localparam logic [6:0]        BASE_MOD100_V = 7'(BASE_MOD100);
  localparam logic [1:0]        BASE_CENT_LO  = 2'(BASE_CENT % 4);

  typedef enum logic [1:0] {
    RC_OK       = 2'd0,
    RC_OSC_STOP = 2'd1,
    RC_BAD_BCD  = 2'd2,
    RC_BAD_DATE = 2'd3
  } result_code_t;

  typedef struct packed {
    logic [7:0] seconds_byte;
    logic [7:0] minutes_byte;
    logic [7:0] hours_byte;
    logic [7:0] weekday_byte;
    logic [7:0] date_byte;
    logic [7:0] month_byte;
    logic [7:0] year_byte;
    logic [7:0] status_byte;
  } in_req_t;

  typedef struct packed {
    result_code_t      result_code;
    logic [YEAR_W-1:0] out_year;
    logic [3:0]        out_month;
    logic [4:0]        out_day;
    logic [2:0]        out_weekday;
    logic [4:0]        out_hour;
    logic [5:0]        out_minute;
    logic [5:0]        out_second;
  } out_res_t;

  // Fields after BCD decode, with the error flags found on the way
  typedef struct packed {
    logic       osc_stop;
    logic       bcd_err;
    logic       h12_err;
    logic [6:0] sec;
    logic [6:0] min;
    logic [5:0] hr;
    logic [2:0] wd;
    logic [5:0] day;
    logic [4:0] mon;
    logic [6:0] yr2;
    logic       century;
  } fields_t;

  function automatic logic bcd_ok(input logic [7:0] v);
    return (v[7:4] <= 4'd9) && (v[3:0] <= 4'd9);
  endfunction

  // hi*10 + lo, with the multiply as two shifts
  function automatic logic [6:0] bcd_val(input logic [7:0] v);
    logic [7:0] hi;
    logic [7:0] sum;
    hi  = {4'd0, v[7:4]};
    sum = (hi << 3) + (hi << 1) + {4'd0, v[3:0]};
    return sum[6:0];
  endfunction

  function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
    logic [4:0] d;
    case (m)
      4'd2:                      d = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   d = 5'd30;
      default:                   d = 5'd31;
    endcase
    return d;
  endfunction

endpackage

// ----- rtl/rtcbcd_field_check.sv -----
// Reserved-bit and BCD digit checks plus 12/24-hour conversion for one register snapshot.
// Depends on rtcbcd_pkg.
module rtcbcd_field_check (
  input  rtcbcd_pkg::in_req_t   req,
  output rtcbcd_pkg::fields_t   fld
);

  logic       rsv_err;
  logic       dig_err;
  logic       hr_dig_err;
  logic [6:0] h12;
  logic [6:0] h12_mod;
  logic [6:0] hr_full;
  logic       h12_err;

  assign rsv_err = req.seconds_byte[7] | req.minutes_byte[7] | req.hours_byte[7] |
                   (req.weekday_byte[7:3] != 5'd0) | (req.date_byte[7:6] != 2'd0) |
                   (req.month_byte[6:5] != 2'd0);

  assign dig_err = !rtcbcd_pkg::bcd_ok({1'b0, req.seconds_byte[6:0]}) |
                   !rtcbcd_pkg::bcd_ok({1'b0, req.minutes_byte[6:0]}) |
                   !rtcbcd_pkg::bcd_ok({2'b0, req.date_byte[5:0]}) |
                   !rtcbcd_pkg::bcd_ok({3'b0, req.month_byte[4:0]}) |
                   !rtcbcd_pkg::bcd_ok(req.year_byte);

  always_comb begin
    h12        = rtcbcd_pkg::bcd_val({3'b0, req.hours_byte[4:0]});
    h12_mod    = (h12 == 7'd12) ? 7'd0 : h12;
    h12_err    = 1'b0;
    if (req.hours_byte[6]) begin
      hr_dig_err = !rtcbcd_pkg::bcd_ok({3'b0, req.hours_byte[4:0]});
      h12_err    = (h12 < 7'd1) || (h12 > 7'd12);
      hr_full    = h12_mod + (req.hours_byte[5] ? 7'd12 : 7'd0);
    end else begin
      hr_dig_err = !rtcbcd_pkg::bcd_ok({2'b0, req.hours_byte[5:0]});
      hr_full    = rtcbcd_pkg::bcd_val({2'b0, req.hours_byte[5:0]});
    end
  end

  always_comb begin
    fld.osc_stop = req.status_byte[7];
    fld.bcd_err  = rsv_err | dig_err | hr_dig_err;
    fld.h12_err  = h12_err;
    fld.sec      = rtcbcd_pkg::bcd_val({1'b0, req.seconds_byte[6:0]});
    fld.min      = rtcbcd_pkg::bcd_val({1'b0, req.minutes_byte[6:0]});
    fld.hr       = hr_full[5:0];
    fld.wd       = req.weekday_byte[2:0];
    fld.day      = 6'(rtcbcd_pkg::bcd_val({2'b0, req.date_byte[5:0]}));
    fld.mon      = 5'(rtcbcd_pkg::bcd_val({3'b0, req.month_byte[4:0]}));
    fld.yr2      = rtcbcd_pkg::bcd_val(req.year_byte);
    fld.century  = req.month_byte[7];
  end

endmodule

// ----- rtl/rtcbcd_date_check.sv -----
// Full year, leap-year month length and range checks; picks the result code and zeroes
// the fields on failure. Depends on rtcbcd_pkg.
module rtcbcd_date_check (
  input  rtcbcd_pkg::fields_t   fld,
  output rtcbcd_pkg::out_res_t  res
);

  logic [rtcbcd_pkg::YEAR_W-1:0] year;
  logic [7:0]                    ysum;
  logic                          ycarry;
  logic [7:0]                    ymod;
  logic [1:0]                    cent_lo;
  logic                          leap;
  logic [4:0]                    mlen;
  logic                          range_err;
  rtcbcd_pkg::result_code_t      code;

  assign year = rtcbcd_pkg::BASE_YEAR_V + {5'd0, fld.yr2} +
                (fld.century ? rtcbcd_pkg::CENTURY_YEARS : '0);

  // Year mod 100 and the low bits of the century number, without a divider
  assign ysum    = {1'b0, rtcbcd_pkg::BASE_MOD100_V} + {1'b0, fld.yr2};
  assign ycarry  = (ysum >= 8'd100);
  assign ymod    = ycarry ? (ysum - 8'd100) : ysum;
  assign cent_lo = rtcbcd_pkg::BASE_CENT_LO + {1'b0, ycarry} + {1'b0, fld.century};
  assign leap    = (year[1:0] == 2'd0) && ((ymod != 8'd0) || (cent_lo == 2'd0));
  assign mlen    = rtcbcd_pkg::month_days(fld.mon[3:0], leap);

  assign range_err = (year < rtcbcd_pkg::BASE_YEAR_V) || (year > rtcbcd_pkg::LAST_YEAR_V) ||
                     (fld.mon < 5'd1) || (fld.mon > 5'd12) ||
                     (fld.day < 6'd1) || (fld.day > {1'b0, mlen}) ||
                     (fld.wd == 3'd0) ||
                     (fld.hr >= 6'd24) || (fld.min >= 7'd60) || (fld.sec >= 7'd60);

  always_comb begin
    if (fld.osc_stop) begin
      code = rtcbcd_pkg::RC_OSC_STOP;
    end else if (fld.bcd_err) begin
      code = rtcbcd_pkg::RC_BAD_BCD;
    end else if (fld.h12_err || range_err) begin
      code = rtcbcd_pkg::RC_BAD_DATE;
    end else begin
      code = rtcbcd_pkg::RC_OK;
    end
  end

  always_comb begin
    res             = '0;
    res.result_code = code;
    if (code == rtcbcd_pkg::RC_OK) begin
      res.out_year    = year;
      res.out_month   = fld.mon[3:0];
      res.out_day     = fld.day[4:0];
      res.out_weekday = fld.wd;
      res.out_hour    = fld.hr[4:0];
      res.out_minute  = fld.min[5:0];
      res.out_second  = fld.sec[5:0];
    end
  end

endmodule

// ----- rtl/rtc_bcd_datetime_decode.sv -----
// Top level of the RTC date/time register decoder: input register, decode logic,
// result register. Depends on rtcbcd_pkg, rtcbcd_field_check, rtcbcd_date_check.
//
// Usage: present the eight raw register bytes (seconds through status) on in_data and
// raise start for one cycle per request. busy stays low, so a request is taken in every
// cycle that start is high; back-to-back requests stream at one per clock.
// Each request yields exactly one result: the request is captured in
// the input register on the accepting edge, decoded by the field and date checks, and
// captured in the result register on the next edge. out_valid is high for that one
// cycle with out_data holding the result code and the decoded date and time (all
// fields zero unless the code is success).
// The receiver cannot stall; a result must be taken in the cycle it is shown.
// Synchronous active-low reset clears the valid pipeline so no result appears until a
// new request arrives; requests in flight at reset are dropped.
module rtc_bcd_datetime_decode (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  rtcbcd_pkg::in_req_t  in_data,
  output logic                 out_valid,
  output rtcbcd_pkg::out_res_t out_data
);

  rtcbcd_pkg::in_req_t  in_data_r;
  logic                 in_vld_r;
  rtcbcd_pkg::fields_t  fld;
  rtcbcd_pkg::out_res_t res_nxt;
  rtcbcd_pkg::out_res_t res_r;
  logic                 out_vld_r;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= start && !busy;
      out_vld_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      in_data_r <= in_data;
    end
    if (in_vld_r) begin
      res_r <= res_nxt;
    end
  end

  rtcbcd_field_check u_field_check (
    .req (in_data_r),
    .fld (fld)
  );

  rtcbcd_date_check u_date_check (
    .fld (fld),
    .res (res_nxt)
  );

  assign out_valid = out_vld_r;
  assign out_data  = res_r;

  // Every accepted request comes out through the input and result registers
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##2 out_valid)
    else $error("accepted request did not produce a result");

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, 2))
    else $error("result without a request");

  a_zero_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.result_code != rtcbcd_pkg::RC_OK) |->
      (out_data.out_year == '0 && out_data.out_month == '0 && out_data.out_day == '0 &&
       out_data.out_weekday == '0 && out_data.out_hour == '0 &&
       out_data.out_minute == '0 && out_data.out_second == '0))
    else $error("nonzero field on failed decode");

  a_ok_ranges: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.result_code == rtcbcd_pkg::RC_OK) |->
      (out_data.out_month >= 4'd1 && out_data.out_month <= 4'd12 &&
       out_data.out_day != 5'd0 && out_data.out_weekday != 3'd0 &&
       out_data.out_hour < 5'd24 && out_data.out_minute < 6'd60 &&
       out_data.out_second < 6'd60))
    else $error("successful decode out of range");

  a_osc_priority: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_data.status_byte[7]) |->
      ##2 (out_data.result_code == rtcbcd_pkg::RC_OSC_STOP))
    else $error("oscillator-stop flag not reported first");

endmodule

// ----- tb/sv/tb.sv -----
// Testbench for rtc_bcd_datetime_decode: directed and random register snapshots, results
// checked against an in-bench decoder model through a small scoreboard.
// Depends on rtcbcd_pkg and the rtc_bcd_datetime_decode RTL.
`timescale 1ns / 100ps

module tb;

  class datetime_scoreboard;
    rtcbcd_pkg::out_res_t expected_decodes[$];
    int                   fail_count;

    function int bcd_value(input logic [7:0] v);
      if (v[7:4] > 4'd9 || v[3:0] > 4'd9) return -1;
      return v[7:4] * 10 + v[3:0];
    endfunction

    function int days_of_month(input int yr, input int mo);
      bit leap_yr;
      leap_yr = (yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0));
      case (mo)
        2:           return leap_yr ? 29 : 28;
        4, 6, 9, 11: return 30;
        default:     return 31;
      endcase
    endfunction

    function rtcbcd_pkg::out_res_t predict_decode(input rtcbcd_pkg::in_req_t r);
      rtcbcd_pkg::out_res_t     res;
      rtcbcd_pkg::result_code_t code;
      int                       se, mi, hr, h12, dd, mo, y2, wd, yr;
      res  = '0;
      code = rtcbcd_pkg::RC_OK;
      hr   = 0;
      wd   = 0;
      yr   = 0;
      se   = bcd_value({1'b0, r.seconds_byte[6:0]});
      mi   = bcd_value({1'b0, r.minutes_byte[6:0]});
      dd   = bcd_value({2'b0, r.date_byte[5:0]});
      mo   = bcd_value({3'b0, r.month_byte[4:0]});
      y2   = bcd_value(r.year_byte);
      if (r.status_byte[7]) begin
        code = rtcbcd_pkg::RC_OSC_STOP;
      end else if (r.seconds_byte[7] || r.minutes_byte[7] || r.hours_byte[7] ||
                   r.weekday_byte[7:3] != 5'd0 || r.date_byte[7:6] != 2'd0 ||
                   r.month_byte[6:5] != 2'd0) begin
        code = rtcbcd_pkg::RC_BAD_BCD;
      end else if (se < 0 || mi < 0 || dd < 0 || mo < 0 || y2 < 0) begin
        code = rtcbcd_pkg::RC_BAD_BCD;
      end else begin
        if (r.hours_byte[6]) begin
          h12 = bcd_value({3'b0, r.hours_byte[4:0]});
          if (h12 < 0) code = rtcbcd_pkg::RC_BAD_BCD;
          else if (h12 < 1 || h12 > 12) code = rtcbcd_pkg::RC_BAD_DATE;
          else hr = (h12 % 12) + (r.hours_byte[5] ? 12 : 0);
        end else begin
          hr = bcd_value({2'b0, r.hours_byte[5:0]});
          if (hr < 0) code = rtcbcd_pkg::RC_BAD_BCD;
        end
        if (code == rtcbcd_pkg::RC_OK) begin
          wd = r.weekday_byte[2:0];
          yr = rtcbcd_pkg::BASE_YEAR + y2 + (r.month_byte[7] ? 100 : 0);
          if (yr < rtcbcd_pkg::BASE_YEAR || yr > rtcbcd_pkg::LAST_YEAR || mo < 1 || mo > 12 ||
              dd < 1 || dd > days_of_month(yr, mo) || wd < 1 || wd > 7 ||
              hr >= 24 || mi >= 60 || se >= 60)
            code = rtcbcd_pkg::RC_BAD_DATE;
        end
      end
      res.result_code = code;
      if (code == rtcbcd_pkg::RC_OK) begin
        res.out_year    = yr[rtcbcd_pkg::YEAR_W-1:0];
        res.out_month   = 4'(mo);
        res.out_day     = 5'(dd);
        res.out_weekday = 3'(wd);
        res.out_hour    = 5'(hr);
        res.out_minute  = 6'(mi);
        res.out_second  = 6'(se);
      end
      return res;
    endfunction

    function void note_request(input rtcbcd_pkg::in_req_t r);
      expected_decodes.push_back(predict_decode(r));
    endfunction

    function void check_result(input rtcbcd_pkg::out_res_t got);
      rtcbcd_pkg::out_res_t exp_res;
      if (expected_decodes.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("%0t: unexpected result code=%0d year=%0d", $realtime,
                   got.result_code, got.out_year);
        return;
      end
      exp_res = expected_decodes.pop_front();
      if (got.result_code !== exp_res.result_code || got.out_year !== exp_res.out_year ||
          got.out_month !== exp_res.out_month || got.out_day !== exp_res.out_day ||
          got.out_weekday !== exp_res.out_weekday || got.out_hour !== exp_res.out_hour ||
          got.out_minute !== exp_res.out_minute || got.out_second !== exp_res.out_second) begin
        fail_count++;
        if (fail_count <= 10) begin
          $display("%0t: mismatch expected code=%0d %0d-%0d-%0d wd=%0d %0d:%0d:%0d", $realtime,
                   exp_res.result_code, exp_res.out_year, exp_res.out_month, exp_res.out_day,
                   exp_res.out_weekday, exp_res.out_hour, exp_res.out_minute,
                   exp_res.out_second);
          $display("%0t:          actual   code=%0d %0d-%0d-%0d wd=%0d %0d:%0d:%0d", $realtime,
                   got.result_code, got.out_year, got.out_month, got.out_day,
                   got.out_weekday, got.out_hour, got.out_minute, got.out_second);
        end
      end
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  rtcbcd_pkg::in_req_t  in_data;
  logic                 out_valid;
  rtcbcd_pkg::out_res_t out_data;

  datetime_scoreboard sb;
  bit                 idle_on;

  rtc_bcd_datetime_decode dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) sb.note_request(in_data);
      if (out_valid) sb.check_result(out_data);
    end
  end

  function automatic logic [7:0] to_bcd(input int v);
    return {4'(v / 10), 4'(v % 10)};
  endfunction

  // hold the request until the block takes it
  task automatic send_request(input rtcbcd_pkg::in_req_t r);
    start   <= 1'b1;
    in_data <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  task automatic send_bytes(input logic [7:0] se, mi, hr, wd, dd, mo, yr, st);
    send_request({se, mi, hr, wd, dd, mo, yr, st});
  endtask

  function automatic rtcbcd_pkg::in_req_t random_snapshot();
    rtcbcd_pkg::in_req_t r;
    int                  y2, mo, dd, wd, hr, mi, se, h12;
    if ($urandom_range(0, 9) == 0) begin
      r = {$urandom, $urandom};
      return r;
    end
    y2 = $urandom_range(0, 99);
    mo = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 19) : $urandom_range(1, 12);
    dd = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 39) : $urandom_range(1, 28);
    wd = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 7);
    hr = ($urandom_range(0, 19) == 0) ? $urandom_range(24, 29) : $urandom_range(0, 23);
    mi = ($urandom_range(0, 19) == 0) ? $urandom_range(60, 79) : $urandom_range(0, 59);
    se = ($urandom_range(0, 19) == 0) ? $urandom_range(60, 79) : $urandom_range(0, 59);
    r.seconds_byte = to_bcd(se);
    r.minutes_byte = to_bcd(mi);
    r.weekday_byte = 8'(wd);
    r.date_byte    = to_bcd(dd);
    r.month_byte   = to_bcd(mo) | ($urandom_range(0, 1) ? 8'h80 : 8'h00);
    r.year_byte    = to_bcd(y2);
    r.status_byte  = {($urandom_range(0, 19) == 0), 7'($urandom)};
    if (hr < 24 && $urandom_range(0, 1)) begin
      h12 = (hr % 12 == 0) ? 12 : hr % 12;
      if ($urandom_range(0, 29) == 0) h12 = $urandom_range(0, 1) ? 0 : $urandom_range(13, 19);
      r.hours_byte = 8'h40 | (hr >= 12 ? 8'h20 : 8'h00) | to_bcd(h12);
    end else begin
      r.hours_byte = to_bcd(hr);
    end
    // flip one bit now and then to reach reserved bits and bad digits
    if ($urandom_range(0, 9) == 0) r = r ^ (64'd1 << $urandom_range(0, 63));
    return r;
  endfunction

  initial begin
    sb      = new;
    idle_on = 1'b1;
    rst_n   <= 1'b0;
    start   <= 1'b0;
    in_data <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_bytes(8'h00, 8'h00, 8'h00, 8'h01, 8'h01, 8'h01, 8'h00, 8'h00);
    send_bytes(8'h59, 8'h59, 8'h23, 8'h07, 8'h31, 8'h92, 8'h99, 8'h00);
    send_bytes(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    send_bytes(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h80);
    send_bytes(8'h30, 8'h15, 8'h10, 8'h03, 8'h15, 8'h06, 8'h24, 8'h7F);
    send_bytes(8'h80, 8'h15, 8'h10, 8'h03, 8'h15, 8'h06, 8'h24, 8'h00);
    send_bytes(8'h30, 8'h8A, 8'h10, 8'h03, 8'h15, 8'h06, 8'h24, 8'h00);
    send_bytes(8'h30, 8'h15, 8'h90, 8'h03, 8'h15, 8'h06, 8'h24, 8'h00);
    send_bytes(8'h30, 8'h15, 8'h10, 8'h0B, 8'h15, 8'h06, 8'h24, 8'h00);
    send_bytes(8'h30, 8'h15, 8'h10, 8'h03, 8'h55, 8'h06, 8'h24, 8'h00);
    send_bytes(8'h30, 8'h15, 8'h10, 8'h03, 8'h15, 8'h26, 8'h24, 8'h00);
    send_bytes(8'h30, 8'h15, 8'h10, 8'h03, 8'h15, 8'h46, 8'h24, 8'h00);
    send_bytes(8'h5A, 8'h15, 8'h10, 8'h03, 8'h15, 8'h06, 8'h24, 8'h00);
    send_bytes(8'h30, 8'h15, 8'h10, 8'h03, 8'h15, 8'h06, 8'hA5, 8'h00);
    send_bytes(8'h30, 8'h15, 8'h5A, 8'h03, 8'h15, 8'h06, 8'h24, 8'h00);
    send_bytes(8'h30, 8'h15, 8'h40, 8'h03, 8'h15, 8'h06, 8'h24, 8'h00);
    send_bytes(8'h30, 8'h15, 8'h53, 8'h03, 8'h15, 8'h06, 8'h24, 8'h00);
    send_bytes(8'h30, 8'h15, 8'h52, 8'h03, 8'h15, 8'h06, 8'h24, 8'h00);
    send_bytes(8'h30, 8'h15, 8'h72, 8'h03, 8'h15, 8'h06, 8'h24, 8'h00);
    send_bytes(8'h30, 8'h15, 8'h71, 8'h03, 8'h15, 8'h06, 8'h24, 8'h00);
    send_bytes(8'h00, 8'h00, 8'h12, 8'h02, 8'h29, 8'h02, 8'h00, 8'h00);
    send_bytes(8'h00, 8'h00, 8'h12, 8'h02, 8'h29, 8'h82, 8'h00, 8'h00);
    send_bytes(8'h00, 8'h00, 8'h12, 8'h02, 8'h29, 8'h02, 8'h23, 8'h00);
    send_bytes(8'h00, 8'h00, 8'h12, 8'h02, 8'h31, 8'h04, 8'h23, 8'h00);
    send_bytes(8'h60, 8'h60, 8'h24, 8'h02, 8'h15, 8'h13, 8'h23, 8'h00);

    for (int n = 0; n < 1425; n++) begin
      if (n % 50 == 0) idle_on = ($urandom_range(0, 2) != 0);
      if (n >= 1275) idle_on = 1'b0;
      send_request(random_snapshot());
    end
    start <= 1'b0;

    while (sb.expected_decodes.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
    if (sb.fail_count == 0 && sb.expected_decodes.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/rtcbcd_pkg.sv
rtl/rtcbcd_field_check.sv
rtl/rtcbcd_date_check.sv
rtl/rtc_bcd_datetime_decode.sv
tb/sv/tb.sv
